>>> hdl/positional_list_store_top_defines.svh
// Assertion macros for the checker file of the positional list store.
`ifndef POSITIONAL_LIST_STORE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_STORE_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define PLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define PLS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PLS_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pls_pkg.sv
package pls_pkg;

  // Default sizes
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Field widths fixed by the port list
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIND      = 3'd6;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // Per-cycle operation broadcast to every cell
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t CELL_HOLD  = 3'd0;
  localparam cell_op_t CELL_OPEN  = 3'd1;  // shift toward tail, write word at pos
  localparam cell_op_t CELL_CLOSE = 3'd2;  // shift toward head from pos
  localparam cell_op_t CELL_MATCH = 3'd3;  // capture compare flags
  localparam cell_op_t CELL_SCAN  = 3'd4;  // move compare flags toward head

endpackage

>>> hdl/pls_cell.sv
module pls_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pls_pkg::cell_op_t     op,
  input  logic [IDX_W-1:0]      pos,
  input  logic [CNT_W-1:0]      cnt,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] from_lo,
  input  logic [DATA_WIDTH-1:0] from_hi,
  input  logic                  match_hi,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  match
);
  import pls_pkg::*;

  localparam logic [IDX_W-1:0] IDX_P = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  // Stored word: shifts with its neighbors on insert and erase
  always_ff @(posedge clk) begin
    case (op)
      CELL_OPEN: begin
        if (IDX_P > pos) begin
          entry <= from_lo;
        end else if (IDX_P == pos) begin
          entry <= word;
        end
      end
      CELL_CLOSE: begin
        if (IDX_P >= pos) begin
          entry <= from_hi;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

  // Compare flag: set on an occupied matching slot, then walks toward the head
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      case (op)
        CELL_MATCH: match <= (entry == word) && (IDX_C < cnt);
        CELL_SCAN:  match <= match_hi;
        default:    match <= match;
      endcase
    end
  end

endmodule

>>> hdl/positional_list_store_top.sv
// Positional list store: a dense list of up to CAPACITY words held in a row of
// cells, one word per cell. Insert, erase, push and pop move every word at once,
// so each of these requests is done within its acceptance cycle, and a
// new request can be taken every cycle while the response register is free.
// Find compares all cells in the acceptance cycle, then shifts the match flags
// one cell per cycle toward the head: its response is formed when the flag of
// the first match reaches the head cell, or when the scan reaches the count.
// No request is taken during a find. A response that cannot leave because the
// output is stalled waits in a holding register and blocks new requests until
// it moves out. The list needs no clearing after reset.
module positional_list_store_top #(
  parameter int CAPACITY   = pls_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = pls_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pls_pkg::CMD_W-1:0]     cmd,
  input  logic [pls_pkg::POS_W-1:0]     position,
  input  logic [pls_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pls_pkg::STATUS_W-1:0]  status,
  output logic [pls_pkg::FOUND_W-1:0]   found_index,
  output logic [pls_pkg::COUNT_W-1:0]   count
);
  import pls_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] entry_count, count_next;
  logic [CNT_W-1:0] scan_idx, scan_idx_next;

  cell_op_t         cell_op;
  logic [IDX_W-1:0] cell_pos;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH+VALUE_W-1:0] value_ext;

  logic [DATA_WIDTH-1:0] ent    [CAPACITY];
  logic [DATA_WIDTH-1:0] lo_in  [CAPACITY];
  logic [DATA_WIDTH-1:0] hi_in  [CAPACITY];
  logic                  mflag  [CAPACITY];
  logic                  mhi_in [CAPACITY];

  logic [CMP_W-1:0] pos_c, cnt_c, act_pos;
  logic             fin, slot_free;
  logic [STATUS_W-1:0] fin_status, hold_status;
  logic [FOUND_W-1:0]  fin_found, hold_found;
  logic [COUNT_W-1:0]  fin_count, hold_count;
  logic [CNT_W+FOUND_W-1:0] scan_ext;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Keep the low DATA_WIDTH bits of the zero-extended value
  assign value_ext = {{DATA_WIDTH{1'b0}}, value};
  assign word      = value_ext[DATA_WIDTH-1:0];

  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(entry_count);

  // Target position of the current request
  always_comb begin
    case (cmd)
      CMD_PUSH_TAIL: act_pos = cnt_c;
      CMD_INSERT,
      CMD_ERASE:     act_pos = pos_c;
      default:       act_pos = '0;
    endcase
  end

  assign cell_pos  = act_pos[IDX_W-1:0];
  assign scan_ext  = {{FOUND_W{1'b0}}, scan_idx};
  assign count_ext = {{COUNT_W{1'b0}}, count_next};
  assign fin_count = count_ext[COUNT_W-1:0];

  // Request decode and find sequencing
  always_comb begin
    cell_op       = CELL_HOLD;
    fin           = 1'b0;
    fin_status    = ST_BAD;
    fin_found     = '0;
    count_next    = entry_count;
    scan_idx_next = scan_idx;
    state_next    = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          fin = 1'b1;
          case (cmd)
            CMD_PUSH_TAIL,
            CMD_PUSH_HEAD,
            CMD_INSERT: begin
              if (act_pos > cnt_c) begin
                fin_status = ST_BAD;
              end else if (entry_count == CAP_C) begin
                fin_status = ST_FULL;
              end else begin
                fin_status = ST_DONE;
                cell_op    = CELL_OPEN;
                count_next = entry_count + CNT_W'(1);
              end
            end
            CMD_POP_TAIL,
            CMD_POP_HEAD,
            CMD_ERASE: begin
              if (act_pos < cnt_c) begin
                fin_status = ST_DONE;
                count_next = entry_count - CNT_W'(1);
                if (cmd != CMD_POP_TAIL) begin
                  cell_op = CELL_CLOSE;
                end
              end
            end
            CMD_FIND: begin
              fin           = 1'b0;
              cell_op       = CELL_MATCH;
              scan_idx_next = '0;
              state_next    = S_SCAN;
            end
            default: begin
              fin_status = ST_BAD;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_idx == entry_count) begin
          fin        = 1'b1;
          fin_status = ST_MISS;
        end else if (mflag[0]) begin
          fin        = 1'b1;
          fin_status = ST_DONE;
          fin_found  = scan_ext[FOUND_W-1:0];
        end else begin
          cell_op       = CELL_SCAN;
          scan_idx_next = scan_idx + CNT_W'(1);
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = slot_free ? S_IDLE : S_HOLD;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_idx    <= '0;
    end else begin
      state       <= state_next;
      entry_count <= count_next;
      scan_idx    <= scan_idx_next;
    end
  end

  // Response register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((fin || state == S_HOLD) && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response payload and holding register
  always_ff @(posedge clk) begin
    if (fin && slot_free) begin
      status      <= fin_status;
      found_index <= fin_found;
      count       <= fin_count;
    end else if (state == S_HOLD && slot_free) begin
      status      <= hold_status;
      found_index <= hold_found;
      count       <= hold_count;
    end
    if (fin && !slot_free) begin
      hold_status <= fin_status;
      hold_found  <= fin_found;
      hold_count  <= fin_count;
    end
  end

  // Row of cells, each inner cell wired to its two neighbors, each end cell to one
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lo_in[g] = word;
    end else begin : g_mid_lo
      assign lo_in[g] = ent[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign hi_in[g]  = ent[g];
      assign mhi_in[g] = 1'b0;
    end else begin : g_mid_hi
      assign hi_in[g]  = ent[g+1];
      assign mhi_in[g] = mflag[g+1];
    end

    pls_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (cell_op),
      .pos      (cell_pos),
      .cnt      (entry_count),
      .word     (word),
      .from_lo  (lo_in[g]),
      .from_hi  (hi_in[g]),
      .match_hi (mhi_in[g]),
      .entry    (ent[g]),
      .match    (mflag[g])
    );
  end

endmodule

>>> hdl/pls_checker.sv
`include "positional_list_store_top_defines.svh"

module pls_checker #(
  parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pls_pkg::STATUS_W-1:0]  status,
  input logic [pls_pkg::FOUND_W-1:0]   found_index,
  input logic [pls_pkg::COUNT_W-1:0]   count
);
  import pls_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_LOW = COUNT_W'(CAPACITY % 32);

  // A stalled response holds
  `PLS_ASSERT_NXT(a_rsp_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({status, found_index, count}), "response changed while stalled")

  // A nonzero index only comes with a successful find
  `PLS_ASSERT_IMP(a_found_done, clk, rst, out_valid && (found_index != '0), status == ST_DONE, "found index on a failed response")

  // A full refusal reports a full list
  `PLS_ASSERT_IMP(a_full_count, clk, rst, out_valid && (status == ST_FULL), count == CAP_LOW, "full refusal with list not full")

  // Reset empties the response register
  `PLS_ASSERT_NXT_ALL(a_rst_clear, clk, rst, !out_valid, "response valid after reset")

endmodule

bind positional_list_store_top pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (.*);
